// ===== sv/rk4_pkg.sv =====
// Shared types and constants for the RK4 complex linear step unit.
`default_nettype none
package rk4_pkg;

  localparam logic [2:0] OP_LOAD_START = 3'd0;
  localparam logic [2:0] OP_LOAD_MID   = 3'd1;
  localparam logic [2:0] OP_LOAD_END   = 3'd2;
  localparam logic [2:0] OP_LOAD_STATE = 3'd3;
  localparam logic [2:0] OP_STEP       = 3'd4;
  localparam logic [2:0] OP_READ       = 3'd5;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_DT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SINGLE = 2'd2;

  localparam logic [23:0] DT_RESET   = 24'd65536;
  localparam logic [4:0]  SIZE_RESET = 5'd16;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic signed [31:0] value_real;
    logic signed [31:0] value_imag;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         elem_index;
    logic signed [31:0] elem_real;
    logic signed [31:0] elem_imag;
    logic               overflow;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } cval_t;

  typedef struct packed {
    logic vld;
    logic clr;
    logic shl;
  } mac_ctl_t;

  typedef enum logic [1:0] {
    FM_RND,
    FM_DIV2,
    FM_DIV1,
    FM_DIV6
  } fin_mode_t;

  typedef struct packed {
    logic      start;
    fin_mode_t mode;
  } fin_req_t;

endpackage
`default_nettype wire

// ===== sv/rk4_dense_complex_linear_step_unit.sv =====
// Top level: RK4 step sequencer, matrix and vector stores, item channels.
`default_nettype none
// Advances a complex Q(32-F).F state vector by one fourth-order Runge-Kutta step
// of dr/dt = L r using up to three dense complex matrices held on chip. Load
// items write one matrix or vector entry each; read emits the n vector elements;
// a step runs four matrix-vector products, the stage inputs and the update on
// one complex multiply-accumulate unit, one matrix entry per cycle, each
// result element then passing through a rounding and saturation unit. Input
// is stalled for the whole step or read. Entries never loaded read as undefined.
module rk4_dense_complex_linear_step_unit #(
  parameter int MAX_DIM   = 16,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire rk4_pkg::in_item_t                  in_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output rk4_pkg::out_item_t                      out_data,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [rk4_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rk4_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int CNT_W = $clog2(MAX_DIM + 1);
  localparam int JW    = (CNT_W > 3) ? CNT_W : 3;
  localparam int MAT_D = 1 << (2 * IDX_W);
  localparam int VEC_D = 1 << IDX_W;
  localparam int SLP_D = 4 * VEC_D;
  localparam int ACC_W = 66 + $clog2(MAX_DIM);

  typedef enum logic [2:0] {
    ST_IDLE, ST_ISSUE, ST_DRAIN, ST_FIN, ST_EMIT_ADDR, ST_EMIT_LOAD
  } st_t;
  typedef enum logic [1:0] {PH_MV, PH_SI, PH_UPD} ph_t;
  typedef enum logic [1:0] {XS_SV, XS_SI, XS_SLP} xs_t;

  // configuration
  logic [23:0] dt_r;
  logic [4:0]  size_r;
  logic        single_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r     <= rk4_pkg::DT_RESET;
      size_r   <= rk4_pkg::SIZE_RESET;
      single_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rk4_pkg::CFG_DT:     dt_r     <= cfg_data;
        rk4_pkg::CFG_SIZE:   size_r   <= cfg_data[4:0];
        rk4_pkg::CFG_SINGLE: single_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer state
  st_t             state_r;
  ph_t             phase_r;
  logic [1:0]      stage_r;
  logic [CNT_W-1:0] i_r, n_r, e_r;
  logic [JW-1:0]   j_r;
  logic [1:0]      drain_r;
  logic            ovf_r, emit_ovf_r;
  rk4_pkg::mac_ctl_t iss_r;
  logic            src_dt_r;
  xs_t             xsel_r;
  logic [1:0]      msel_r;
  logic            out_vld_r;
  rk4_pkg::out_item_t out_r;

  logic            accept;
  logic [CNT_W-1:0] n_dim;
  logic [JW-1:0]   lim;
  logic [IDX_W-1:0] i_idx, j_idx, e_idx;
  logic            out_free;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign i_idx    = i_r[IDX_W-1:0];
  assign j_idx    = j_r[IDX_W-1:0];
  assign e_idx    = e_r[IDX_W-1:0];
  assign out_free = !out_vld_r || !out_stall;

  always_comb begin
    if (size_r == 5'd0) begin
      n_dim = CNT_W'(1);
    end else if (32'(size_r) > MAX_DIM) begin
      n_dim = CNT_W'(MAX_DIM);
    end else begin
      n_dim = CNT_W'(size_r);
    end
    case (phase_r)
      PH_MV:   lim = JW'(n_r);
      PH_SI:   lim = JW'(1);
      default: lim = JW'(4);
    endcase
  end

  // stores
  rk4_pkg::cval_t mat0_mem [MAT_D];
  rk4_pkg::cval_t mat1_mem [MAT_D];
  rk4_pkg::cval_t mat2_mem [MAT_D];
  rk4_pkg::cval_t sv_mem   [VEC_D];
  rk4_pkg::cval_t si_mem   [VEC_D];
  rk4_pkg::cval_t slp_mem  [SLP_D];
  rk4_pkg::cval_t mat0_rd_r, mat1_rd_r, mat2_rd_r, sv_rd_r, si_rd_r, slp_rd_r;

  rk4_pkg::cval_t       ld_val, fin_res, mat_rd, x_rd;
  logic                 ld_ok, fin_done, fin_ovf;
  logic [2*IDX_W-1:0]   ld_maddr, mat_raddr;
  logic [IDX_W-1:0]     ld_vaddr, sv_raddr;
  logic [IDX_W+1:0]     slp_raddr;
  logic [1:0]           slot;

  assign ld_val.re = in_data.value_real;
  assign ld_val.im = in_data.value_imag;
  assign ld_ok     = (32'(in_data.row_index) < MAX_DIM) &&
                     (32'(in_data.col_index) < MAX_DIM);
  assign ld_maddr  = {IDX_W'(in_data.row_index), IDX_W'(in_data.col_index)};
  assign ld_vaddr  = IDX_W'(in_data.row_index);
  assign mat_raddr = {i_idx, j_idx};
  assign slot      = (phase_r == PH_SI) ? 2'(stage_r - 2'd1) : j_r[1:0];
  assign slp_raddr = {slot, i_idx};

  always_comb begin
    if (state_r == ST_ISSUE && phase_r == PH_MV) begin
      sv_raddr = j_idx;
    end else if (state_r == ST_EMIT_ADDR || state_r == ST_EMIT_LOAD) begin
      sv_raddr = e_idx;
    end else begin
      sv_raddr = i_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.opcode == rk4_pkg::OP_LOAD_START && ld_ok) begin
      mat0_mem[ld_maddr] <= ld_val;
    end
    mat0_rd_r <= mat0_mem[mat_raddr];
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.opcode == rk4_pkg::OP_LOAD_MID && ld_ok) begin
      mat1_mem[ld_maddr] <= ld_val;
    end
    mat1_rd_r <= mat1_mem[mat_raddr];
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.opcode == rk4_pkg::OP_LOAD_END && ld_ok) begin
      mat2_mem[ld_maddr] <= ld_val;
    end
    mat2_rd_r <= mat2_mem[mat_raddr];
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.opcode == rk4_pkg::OP_LOAD_STATE &&
        32'(in_data.row_index) < MAX_DIM) begin
      sv_mem[ld_vaddr] <= ld_val;
    end else if (fin_done && phase_r == PH_UPD) begin
      sv_mem[i_idx] <= fin_res;
    end
    sv_rd_r <= sv_mem[sv_raddr];
  end

  always_ff @(posedge clk) begin
    if (fin_done && phase_r == PH_SI) begin
      si_mem[i_idx] <= fin_res;
    end
    si_rd_r <= si_mem[j_idx];
  end

  always_ff @(posedge clk) begin
    if (fin_done && phase_r == PH_MV) begin
      slp_mem[{stage_r, i_idx}] <= fin_res;
    end
    slp_rd_r <= slp_mem[slp_raddr];
  end

  // shared arithmetic
  logic signed [31:0]      a_re, a_im;
  logic signed [ACC_W-1:0] acc_re, acc_im;
  rk4_pkg::fin_req_t       fin_req;
  rk4_pkg::cval_t          fin_base;

  always_comb begin
    case (msel_r)
      2'd1:    mat_rd = mat1_rd_r;
      2'd2:    mat_rd = mat2_rd_r;
      default: mat_rd = mat0_rd_r;
    endcase
    case (xsel_r)
      XS_SV:   x_rd = sv_rd_r;
      XS_SI:   x_rd = si_rd_r;
      default: x_rd = slp_rd_r;
    endcase
    a_re = src_dt_r ? $signed({8'd0, dt_r}) : mat_rd.re;
    a_im = src_dt_r ? 32'sd0 : mat_rd.im;
    fin_req.start = (state_r == ST_DRAIN) && (drain_r == 2'd0);
    case (phase_r)
      PH_MV:   fin_req.mode = rk4_pkg::FM_RND;
      PH_SI:   fin_req.mode = (stage_r == 2'd3) ? rk4_pkg::FM_DIV1 : rk4_pkg::FM_DIV2;
      default: fin_req.mode = rk4_pkg::FM_DIV6;
    endcase
    fin_base = sv_rd_r;
  end

  rk4_cmac #(.ACC_W(ACC_W)) u_cmac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (iss_r),
    .a_re   (a_re),
    .a_im   (a_im),
    .x_re   (x_rd.re),
    .x_im   (x_rd.im),
    .acc_re (acc_re),
    .acc_im (acc_im)
  );

  rk4_fin #(.ACC_W(ACC_W), .FRAC_BITS(FRAC_BITS)) u_fin (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (fin_req),
    .acc_re (acc_re),
    .acc_im (acc_im),
    .base   (fin_base),
    .done   (fin_done),
    .res    (fin_res),
    .ovf    (fin_ovf)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      phase_r    <= PH_MV;
      stage_r    <= '0;
      i_r        <= '0;
      j_r        <= '0;
      n_r        <= '0;
      e_r        <= '0;
      drain_r    <= '0;
      ovf_r      <= 1'b0;
      emit_ovf_r <= 1'b0;
      iss_r      <= '0;
      src_dt_r   <= 1'b0;
      xsel_r     <= XS_SV;
      msel_r     <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      if (state_r != ST_ISSUE) begin
        iss_r <= '0;
      end
      if (out_vld_r && !out_stall && state_r != ST_EMIT_LOAD) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_data.opcode == rk4_pkg::OP_STEP) begin
              n_r     <= n_dim;
              stage_r <= '0;
              phase_r <= PH_MV;
              i_r     <= '0;
              j_r     <= '0;
              ovf_r   <= 1'b0;
              state_r <= ST_ISSUE;
            end else if (in_data.opcode == rk4_pkg::OP_READ) begin
              n_r        <= n_dim;
              e_r        <= '0;
              emit_ovf_r <= 1'b0;
              state_r    <= ST_EMIT_ADDR;
            end
          end
        end
        ST_ISSUE: begin
          iss_r.vld <= 1'b1;
          iss_r.clr <= (j_r == '0);
          iss_r.shl <= (phase_r == PH_UPD) && (j_r == JW'(1) || j_r == JW'(2));
          src_dt_r  <= (phase_r != PH_MV);
          if (phase_r != PH_MV) begin
            xsel_r <= XS_SLP;
          end else if (stage_r == 2'd0) begin
            xsel_r <= XS_SV;
          end else begin
            xsel_r <= XS_SI;
          end
          if (single_r || stage_r == 2'd0) begin
            msel_r <= 2'd0;
          end else if (stage_r == 2'd3) begin
            msel_r <= 2'd2;
          end else begin
            msel_r <= 2'd1;
          end
          j_r <= j_r + JW'(1);
          if (j_r + JW'(1) == lim) begin
            drain_r <= 2'd3;
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (drain_r == 2'd0) begin
            state_r <= ST_FIN;
          end else begin
            drain_r <= drain_r - 2'd1;
          end
        end
        ST_FIN: begin
          if (fin_done) begin
            ovf_r <= ovf_r | fin_ovf;
            j_r   <= '0;
            if (i_r + CNT_W'(1) < n_r) begin
              i_r     <= i_r + CNT_W'(1);
              state_r <= ST_ISSUE;
            end else begin
              i_r <= '0;
              unique case (phase_r)
                PH_MV: begin
                  if (stage_r == 2'd3) begin
                    phase_r <= PH_UPD;
                  end else begin
                    stage_r <= stage_r + 2'd1;
                    phase_r <= PH_SI;
                  end
                  state_r <= ST_ISSUE;
                end
                PH_SI: begin
                  phase_r <= PH_MV;
                  state_r <= ST_ISSUE;
                end
                default: begin
                  emit_ovf_r <= ovf_r | fin_ovf;
                  e_r        <= '0;
                  state_r    <= ST_EMIT_ADDR;
                end
              endcase
            end
          end
        end
        ST_EMIT_ADDR: begin
          state_r <= ST_EMIT_LOAD;
        end
        ST_EMIT_LOAD: begin
          if (out_free) begin
            out_vld_r           <= 1'b1;
            out_r.elem_index    <= 4'(e_r);
            out_r.elem_real     <= sv_rd_r.re;
            out_r.elem_imag     <= sv_rd_r.im;
            out_r.overflow      <= emit_ovf_r;
            out_r.last          <= (e_r + CNT_W'(1) == n_r);
            if (e_r + CNT_W'(1) == n_r) begin
              state_r <= ST_IDLE;
            end else begin
              e_r     <= e_r + CNT_W'(1);
              state_r <= ST_EMIT_ADDR;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== sv/rk4_cmac.sv =====
// Pipelined complex multiply-accumulate unit with wide accumulators.
`default_nettype none
module rk4_cmac #(
  parameter int ACC_W = 70
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rk4_pkg::mac_ctl_t  ctl,
  input  wire logic signed [31:0] a_re,
  input  wire logic signed [31:0] a_im,
  input  wire logic signed [31:0] x_re,
  input  wire logic signed [31:0] x_im,
  output logic signed [ACC_W-1:0] acc_re,
  output logic signed [ACC_W-1:0] acc_im
);

  rk4_pkg::mac_ctl_t ctl1_r, ctl2_r;
  logic signed [63:0] p_ac_r, p_bd_r, p_ad_r, p_bc_r;
  logic signed [64:0] s_re_r, s_im_r;
  logic signed [ACC_W-1:0] acc_re_r, acc_im_r;
  logic signed [ACC_W-1:0] add_re, add_im;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else begin
      ctl1_r <= ctl;
      ctl2_r <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    p_ac_r <= a_re * x_re;
    p_bd_r <= a_im * x_im;
    p_ad_r <= a_re * x_im;
    p_bc_r <= a_im * x_re;
    s_re_r <= 65'(p_ac_r) - 65'(p_bd_r);
    s_im_r <= 65'(p_ad_r) + 65'(p_bc_r);
  end

  always_comb begin
    add_re = ctl2_r.shl ? (ACC_W'(s_re_r) <<< 1) : ACC_W'(s_re_r);
    add_im = ctl2_r.shl ? (ACC_W'(s_im_r) <<< 1) : ACC_W'(s_im_r);
  end

  always_ff @(posedge clk) begin
    if (ctl2_r.vld) begin
      acc_re_r <= (ctl2_r.clr ? '0 : acc_re_r) + add_re;
      acc_im_r <= (ctl2_r.clr ? '0 : acc_im_r) + add_im;
    end
  end

  assign acc_re = acc_re_r;
  assign acc_im = acc_im_r;

endmodule
`default_nettype wire

// ===== sv/rk4_fin.sv =====
// Finishing unit: rounds, scales by constant divisors, adds a base and saturates.
`default_nettype none
module rk4_fin #(
  parameter int ACC_W     = 70,
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rk4_pkg::fin_req_t  req,
  input  wire logic signed [ACC_W-1:0] acc_re,
  input  wire logic signed [ACC_W-1:0] acc_im,
  input  wire rk4_pkg::cval_t     base,
  output logic                    done,
  output rk4_pkg::cval_t          res,
  output logic                    ovf
);

  localparam int DIV_STEPS = 9;
  localparam logic signed [37:0] SAT_HI = 38'sd2147483647;
  localparam logic signed [37:0] SAT_LO = -38'sd2147483648;

  typedef enum logic [1:0] {F_IDLE, F_ADD, F_DIV, F_SUM} fst_t;

  fst_t                state_r;
  rk4_pkg::fin_mode_t  mode_r;
  logic [3:0]          cnt_r;
  logic                neg_r [2];
  logic [ACC_W-1:0]    mag_r [2];
  logic signed [31:0]  base_r [2];
  logic [35:0]         dv_r [2];
  logic                done_r, ovf_r;
  rk4_pkg::cval_t      res_r;

  logic signed [ACC_W-1:0] acc_l [2];
  logic [ACC_W-1:0]    mag_in [2];
  logic [ACC_W:0]      m2 [2];
  logic [ACC_W:0]      t [2];
  logic [34:0]         u [2];
  logic signed [37:0]  v [2];
  logic signed [31:0]  sat_v [2];
  logic                sat_f [2];

  always_comb begin
    acc_l[0] = acc_re;
    acc_l[1] = acc_im;
    for (int k = 0; k < 2; k++) begin
      mag_in[k] = acc_l[k][ACC_W-1] ? ACC_W'(-acc_l[k]) : ACC_W'(acc_l[k]);
      case (mode_r)
        rk4_pkg::FM_RND: begin
          m2[k] = {1'b0, mag_r[k]} + ((ACC_W+1)'(1) << (FRAC_BITS - 1));
          t[k]  = m2[k] >> FRAC_BITS;
        end
        rk4_pkg::FM_DIV2: begin
          m2[k] = {1'b0, mag_r[k]} + ((ACC_W+1)'(1) << 24);
          t[k]  = m2[k] >> 25;
        end
        rk4_pkg::FM_DIV1: begin
          m2[k] = {1'b0, mag_r[k]} + ((ACC_W+1)'(1) << 23);
          t[k]  = m2[k] >> 24;
        end
        default: begin
          m2[k] = {1'b0, mag_r[k]} + ((ACC_W+1)'(3) << 24);
          t[k]  = m2[k] >> 25;
        end
      endcase
      u[k] = (|t[k][ACC_W:35]) ? '1 : t[k][34:0];
      v[k] = 38'(base_r[k]) + (neg_r[k] ? -$signed({2'b00, dv_r[k]})
                                         : $signed({2'b00, dv_r[k]}));
      if (v[k] > SAT_HI) begin
        sat_v[k] = 32'sh7fffffff;
        sat_f[k] = 1'b1;
      end else if (v[k] < SAT_LO) begin
        sat_v[k] = -32'sh7fffffff - 32'sd1;
        sat_f[k] = 1'b1;
      end else begin
        sat_v[k] = 32'(v[k]);
        sat_f[k] = 1'b0;
      end
    end
  end

  // remainder of each division step carries into the next nibble
  logic [1:0] rem_r [2];
  logic [1:0] rem_nxt [2];
  always_comb begin
    logic [2:0] t3;
    for (int k = 0; k < 2; k++) begin
      rem_nxt[k] = rem_r[k];
      for (int b = 3; b >= 0; b--) begin
        t3 = {rem_nxt[k], dv_r[k][32+b]};
        rem_nxt[k] = (t3 >= 3'd3) ? 2'(t3 - 3'd3) : t3[1:0];
      end
    end
  end

  logic [35:0] dq_nxt [2];
  always_comb begin
    logic [1:0] rem;
    logic [2:0] t3;
    logic [3:0] qb;
    for (int k = 0; k < 2; k++) begin
      rem = rem_r[k];
      qb  = 4'd0;
      for (int b = 3; b >= 0; b--) begin
        t3 = {rem, dv_r[k][32+b]};
        if (t3 >= 3'd3) begin
          rem   = 2'(t3 - 3'd3);
          qb[b] = 1'b1;
        end else begin
          rem = t3[1:0];
        end
      end
      dq_nxt[k] = {dv_r[k][31:0], qb};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      done_r  <= 1'b0;
      ovf_r   <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= (state_r == F_SUM);
      unique case (state_r)
        F_IDLE: begin
          if (req.start) begin
            mode_r <= req.mode;
            for (int k = 0; k < 2; k++) begin
              neg_r[k] <= acc_l[k][ACC_W-1];
              mag_r[k] <= mag_in[k];
            end
            base_r[0] <= (req.mode == rk4_pkg::FM_RND) ? 32'sd0 : base.re;
            base_r[1] <= (req.mode == rk4_pkg::FM_RND) ? 32'sd0 : base.im;
            state_r   <= F_ADD;
          end
        end
        F_ADD: begin
          for (int k = 0; k < 2; k++) begin
            dv_r[k]  <= {1'b0, u[k]};
            rem_r[k] <= 2'd0;
          end
          cnt_r   <= '0;
          state_r <= (mode_r == rk4_pkg::FM_DIV6) ? F_DIV : F_SUM;
        end
        F_DIV: begin
          for (int k = 0; k < 2; k++) begin
            dv_r[k]  <= dq_nxt[k];
            rem_r[k] <= rem_nxt[k];
          end
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'(DIV_STEPS - 1)) begin
            state_r <= F_SUM;
          end
        end
        F_SUM: begin
          res_r.re <= sat_v[0];
          res_r.im <= sat_v[1];
          ovf_r    <= sat_f[0] | sat_f[1];
          state_r  <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign res  = res_r;
  assign ovf  = ovf_r;

endmodule
`default_nettype wire

// ===== test/rk4_step_checker.sv =====
// Checker for the RK4 step unit: predicts every emitted element and compares.
`timescale 1ns / 100ps
module rk4_step_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  input  wire logic                           in_stall,
  input  wire rk4_pkg::in_item_t              in_data,
  input  wire logic                           out_valid,
  input  wire logic                           out_stall,
  input  wire rk4_pkg::out_item_t             out_data,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [rk4_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rk4_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                  fail_count,
  output int                                  pending
);

  localparam int DIM  = 16;
  localparam int FRAC = 16;
  localparam longint unsigned UNIT = 64'd1 << 24;

  rk4_pkg::cval_t     start_m [DIM*DIM];
  rk4_pkg::cval_t     mid_m   [DIM*DIM];
  rk4_pkg::cval_t     end_m   [DIM*DIM];
  rk4_pkg::cval_t     vec     [DIM];
  rk4_pkg::cval_t     stage_in[DIM];
  rk4_pkg::cval_t     slope   [4][DIM];
  logic [23:0]        dt_reg;
  logic [4:0]         size_reg;
  logic               single_reg;
  rk4_pkg::out_item_t elem_q[$];

  function automatic int eff_dim();
    if (size_reg == 0) return 1;
    if (size_reg > DIM) return DIM;
    return int'(size_reg);
  endfunction

  function automatic logic signed [31:0] sat32(input longint v, inout bit ov);
    if (v > 64'sd2147483647) begin
      ov = 1;
      return 32'sh7FFFFFFF;
    end
    if (v < -64'sd2147483648) begin
      ov = 1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] round_acc(input logic signed [95:0] a, inout bit ov);
    logic [95:0] m;
    logic [95:0] limit;
    bit          neg;
    neg   = a < 0;
    m     = neg ? -a : a;
    m     = (m + (96'd1 << (FRAC - 1))) >> FRAC;
    limit = neg ? 96'h8000_0000 : 96'h7FFF_FFFF;
    if (m > limit) begin
      ov = 1;
      m  = limit;
    end
    return neg ? -m[31:0] : m[31:0];
  endfunction

  function automatic longint div_rnd(input longint v, input longint unsigned d);
    longint unsigned mag;
    longint unsigned q;
    mag = (v < 0) ? longint'(-v) : v;
    q   = (mag + d / 2) / d;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic rk4_pkg::cval_t mat_at(input int sel, input int idx);
    if (sel == 0) return start_m[idx];
    if (sel == 1) return mid_m[idx];
    return end_m[idx];
  endfunction

  task automatic mat_mul(input int sel, input bit from_vec, input int s, input int n,
                         inout bit ov);
    logic signed [95:0] ar;
    logic signed [95:0] ai;
    rk4_pkg::cval_t     m;
    rk4_pkg::cval_t     x;
    for (int i = 0; i < n; i++) begin
      ar = 0;
      ai = 0;
      for (int j = 0; j < n; j++) begin
        m  = mat_at(sel, i * DIM + j);
        x  = from_vec ? vec[j] : stage_in[j];
        ar = ar + (longint'(m.re) * longint'(x.re));
        ar = ar - (longint'(m.im) * longint'(x.im));
        ai = ai + (longint'(m.re) * longint'(x.im));
        ai = ai + (longint'(m.im) * longint'(x.re));
      end
      slope[s][i].re = round_acc(ar, ov);
      slope[s][i].im = round_acc(ai, ov);
    end
  endtask

  task automatic emit_vec(input int n, input bit ov);
    rk4_pkg::out_item_t e;
    for (int i = 0; i < n; i++) begin
      e.elem_index = i[3:0];
      e.elem_real  = vec[i].re;
      e.elem_imag  = vec[i].im;
      e.overflow   = ov;
      e.last       = (i == n - 1);
      elem_q.push_back(e);
    end
  endtask

  task automatic rk4_advance();
    bit              ov;
    int              n;
    int              sel;
    longint          dt;
    longint          sr;
    longint          si;
    longint unsigned d;
    ov = 0;
    n  = eff_dim();
    dt = longint'(dt_reg);
    mat_mul(0, 1, 0, n, ov);
    for (int s = 1; s < 4; s++) begin
      d   = (s < 3) ? 2 * UNIT : UNIT;
      sel = single_reg ? 0 : ((s < 3) ? 1 : 2);
      for (int i = 0; i < n; i++) begin
        stage_in[i].re = sat32(longint'(vec[i].re) + div_rnd(dt * longint'(slope[s-1][i].re), d), ov);
        stage_in[i].im = sat32(longint'(vec[i].im) + div_rnd(dt * longint'(slope[s-1][i].im), d), ov);
      end
      mat_mul(sel, 0, s, n, ov);
    end
    for (int i = 0; i < n; i++) begin
      sr = longint'(slope[0][i].re) + 2 * longint'(slope[1][i].re)
         + 2 * longint'(slope[2][i].re) + longint'(slope[3][i].re);
      si = longint'(slope[0][i].im) + 2 * longint'(slope[1][i].im)
         + 2 * longint'(slope[2][i].im) + longint'(slope[3][i].im);
      vec[i].re = sat32(longint'(vec[i].re) + div_rnd(dt * sr, 6 * UNIT), ov);
      vec[i].im = sat32(longint'(vec[i].im) + div_rnd(dt * si, 6 * UNIT), ov);
    end
    emit_vec(n, ov);
  endtask

  task automatic apply_item(input rk4_pkg::in_item_t it);
    rk4_pkg::cval_t v;
    v.re = it.value_real;
    v.im = it.value_imag;
    case (it.opcode)
      rk4_pkg::OP_LOAD_START: start_m[it.row_index * DIM + it.col_index] = v;
      rk4_pkg::OP_LOAD_MID:   mid_m[it.row_index * DIM + it.col_index] = v;
      rk4_pkg::OP_LOAD_END:   end_m[it.row_index * DIM + it.col_index] = v;
      rk4_pkg::OP_LOAD_STATE: vec[it.row_index] = v;
      rk4_pkg::OP_STEP:       rk4_advance();
      rk4_pkg::OP_READ:       emit_vec(eff_dim(), 0);
      default: ;
    endcase
  endtask

  task automatic check_elem(input rk4_pkg::out_item_t got);
    rk4_pkg::out_item_t want;
    if (elem_q.size() == 0) begin
      $error("unexpected item: index %0d real %0d imag %0d",
             got.elem_index, got.elem_real, got.elem_imag);
      fail_count++;
      return;
    end
    want = elem_q.pop_front();
    if (got.elem_index !== want.elem_index) begin
      $error("elem_index expected %0d actual %0d", want.elem_index, got.elem_index);
      fail_count++;
    end
    if (got.elem_real !== want.elem_real) begin
      $error("elem_real expected %0d actual %0d", want.elem_real, got.elem_real);
      fail_count++;
    end
    if (got.elem_imag !== want.elem_imag) begin
      $error("elem_imag expected %0d actual %0d", want.elem_imag, got.elem_imag);
      fail_count++;
    end
    if (got.overflow !== want.overflow) begin
      $error("overflow expected %0d actual %0d", want.overflow, got.overflow);
      fail_count++;
    end
    if (got.last !== want.last) begin
      $error("last expected %0d actual %0d", want.last, got.last);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      dt_reg     = rk4_pkg::DT_RESET;
      size_reg   = rk4_pkg::SIZE_RESET;
      single_reg = 1'b1;
      elem_q.delete();
    end else begin
      if (out_valid && !out_stall) check_elem(out_data);
      if (in_valid && !in_stall) apply_item(in_data);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rk4_pkg::CFG_DT:     dt_reg = cfg_data[23:0];
          rk4_pkg::CFG_SIZE:   size_reg = cfg_data[4:0];
          rk4_pkg::CFG_SINGLE: single_reg = cfg_data[0];
          default: ;
        endcase
      end
    end
    pending <= elem_q.size();
  end

endmodule

// ===== test/tb_top.sv =====
// Testbench top: clock, reset, stimulus for the RK4 step unit and the verdict.
`timescale 1ns / 100ps
module tb_top;

  localparam int DIM        = 16;
  localparam int IDLE_LIMIT = 30000;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  rk4_pkg::in_item_t              in_data;
  logic                           out_valid;
  logic                           out_stall;
  rk4_pkg::out_item_t             out_data;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [rk4_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rk4_pkg::CFG_DATA_W-1:0] cfg_data;
  int                             fail_count;
  int                             pending;

  bit   calm;
  bit   mat_written[3][DIM*DIM];
  bit   vec_written[DIM];
  int   cur_n;
  bit   cur_single;
  int   stall_left;
  int   idle_cycles;

  rk4_dense_complex_linear_step_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rk4_step_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFFFFFF;
          1: return 32'sh80000000;
          2: return 32'sh00000000;
          default: return 32'shFFFFFFFF;
        endcase
      end
      default: return int'($urandom_range(0, 262144)) - 131072;
    endcase
  endfunction

  task automatic send(input logic [2:0] op, input int row, input int col,
                      input logic signed [31:0] re, input logic signed [31:0] im);
    rk4_pkg::in_item_t it;
    it.opcode     = op;
    it.row_index  = row[3:0];
    it.col_index  = col[3:0];
    it.value_real = re;
    it.value_imag = im;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (op <= rk4_pkg::OP_LOAD_END) mat_written[op][row * DIM + col] = 1;
    if (op == rk4_pkg::OP_LOAD_STATE) vec_written[row] = 1;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [rk4_pkg::CFG_IDX_W-1:0] idx, input int unsigned value);
    drain();
    repeat (10) @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= value[rk4_pkg::CFG_DATA_W-1:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_phase(input int unsigned dt, input int unsigned sz, input bit single);
    cfg_write(rk4_pkg::CFG_DT, dt);
    cfg_write(rk4_pkg::CFG_SIZE, sz);
    cfg_write(rk4_pkg::CFG_SINGLE, single);
    cur_n      = (sz == 0) ? 1 : ((sz > DIM) ? DIM : sz);
    cur_single = single;
  endtask

  task automatic fill_missing(input bit for_step);
    for (int m = 0; m < 3; m++) begin
      if (for_step && (m == 0 || !cur_single)) begin
        for (int i = 0; i < cur_n; i++)
          for (int j = 0; j < cur_n; j++)
            if (!mat_written[m][i * DIM + j])
              send(3'(m), i, j, pick_value(), pick_value());
      end
    end
    for (int i = 0; i < cur_n; i++)
      if (!vec_written[i]) send(rk4_pkg::OP_LOAD_STATE, i, 0, pick_value(), pick_value());
  endtask

  task automatic random_run(input int count);
    int r;
    int hi;
    repeat (count) begin
      r  = $urandom_range(0, 99);
      hi = ($urandom_range(0, 4) == 0) ? DIM - 1 : cur_n - 1;
      if (r < 42) begin
        send(3'($urandom_range(0, 2)), $urandom_range(0, hi), $urandom_range(0, hi),
             pick_value(), pick_value());
      end else if (r < 58) begin
        send(rk4_pkg::OP_LOAD_STATE, $urandom_range(0, hi), $urandom_range(0, 15),
             pick_value(), pick_value());
      end else if (r < 80) begin
        fill_missing(1);
        send(rk4_pkg::OP_STEP, $urandom_range(0, 15), $urandom_range(0, 15),
             $urandom, $urandom);
      end else if (r < 90) begin
        fill_missing(0);
        send(rk4_pkg::OP_READ, $urandom_range(0, 15), $urandom_range(0, 15),
             $urandom, $urandom);
      end else if (r < 95) begin
        send(3'($urandom_range(6, 7)), $urandom_range(0, 15), $urandom_range(0, 15),
             $urandom, $urandom);
      end else begin
        drain();
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    calm      = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every opcode, saturation, unused opcodes
    set_phase(32'd65536, 2, 1);
    send(rk4_pkg::OP_LOAD_START, 0, 0, 32'sh00010000, 32'sh00000000);
    send(rk4_pkg::OP_LOAD_START, 0, 1, 32'sh00000000, 32'sh00008000);
    send(rk4_pkg::OP_LOAD_START, 1, 0, -32'sh00008000, 32'sh00000000);
    send(rk4_pkg::OP_LOAD_START, 1, 1, 32'sh00000000, -32'sh00010000);
    send(rk4_pkg::OP_LOAD_STATE, 0, 0, 32'sh00010000, 32'sh00020000);
    send(rk4_pkg::OP_LOAD_STATE, 1, 0, -32'sh00030000, 32'sh00004000);
    send(rk4_pkg::OP_READ, 0, 0, 0, 0);
    send(rk4_pkg::OP_STEP, 0, 0, 0, 0);
    send(3'd6, 15, 15, 32'shFFFFFFFF, 32'shFFFFFFFF);
    send(3'd7, 0, 0, 0, 0);
    send(rk4_pkg::OP_LOAD_MID, 15, 15, 32'sh7FFFFFFF, 32'sh80000000);
    send(rk4_pkg::OP_LOAD_END, 15, 0, 32'sh80000000, 32'sh7FFFFFFF);
    send(rk4_pkg::OP_LOAD_START, 15, 15, 32'shFFFFFFFF, 32'sh00000000);
    send(rk4_pkg::OP_LOAD_START, 1, 1, 32'sh7FFFFFFF, 32'sh80000000);
    send(rk4_pkg::OP_LOAD_STATE, 1, 0, 32'sh7FFFFFFF, 32'sh80000000);
    send(rk4_pkg::OP_STEP, 15, 15, 32'shFFFFFFFF, 32'shFFFFFFFF);
    send(rk4_pkg::OP_LOAD_STATE, 15, 0, 32'sh00000000, 32'sh00000000);
    send(rk4_pkg::OP_READ, 0, 0, 0, 0);

    set_phase(32'hFFFFFF, 3, 0);
    random_run(90);
    set_phase(32'd1, 1, 0);
    random_run(60);
    set_phase(32'd0, 0, 1);
    random_run(50);
    set_phase($urandom_range(1, 32'hFFFFFF), 4, 0);
    random_run(90);

    calm = 1'b1;
    set_phase($urandom_range(1, 32'h3FFFF), 31, 1);
    fill_missing(0);
    send(rk4_pkg::OP_READ, 0, 0, 0, 0);
    set_phase($urandom_range(1, 32'h3FFFF), 4, 1);
    fill_missing(1);
    send(rk4_pkg::OP_STEP, 0, 0, 0, 0);
    send(rk4_pkg::OP_READ, 0, 0, 0, 0);
    send(rk4_pkg::OP_STEP, 0, 0, 0, 0);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
